// File: rtl/sprite_screen_projection_unit_assert.svh
// Assertion macros shared by the sprite screen projection RTL.
`ifndef SPRITE_SCREEN_PROJECTION_UNIT_ASSERT_SVH
`define SPRITE_SCREEN_PROJECTION_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is active.
`define SSPU_ASSERT_IMPL(label, clk, rstn, pre, post) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (pre) |-> (post)) \
        else $error("sprite projection assertion failed");

// Next-cycle implication, disabled while reset is active.
`define SSPU_ASSERT_NEXT(label, clk, rstn, pre, post) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (pre) |=> (post)) \
        else $error("sprite projection assertion failed");

`endif

// File: rtl/sspu_pkg.sv
// Shared constants and types of the sprite screen projection unit.
package sspu_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_VIEW_POS_X    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_VIEW_POS_Y    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_VIEW_POS_Z    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_VIEW_COSINE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_VIEW_SINE     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_COLUMN = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_PROJECTION    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_VIEW_COLUMNS  = 3'd7;

    localparam int FRAC_BITS    = 16;
    localparam int TRIG_W       = 18;
    localparam int FIX25_W      = 25;
    localparam int OFFSET_W     = 26;
    localparam int COL_W        = 9;
    localparam int SCALE_W      = 24;
    localparam int ISTEP_Q_W    = 30;
    localparam int CLAMP_W      = 17;

    localparam int DETAIL_SHIFT_DEF = 0;

    localparam logic signed [TRIG_W-1:0] VIEW_COSINE_RST   = 18'sd65536;
    localparam logic [FIX25_W-1:0]       CENTER_COLUMN_RST = 25'd10485760;
    localparam logic [FIX25_W-1:0]       PROJECTION_RST    = 25'd10485760;
    localparam logic [COL_W-1:0]         VIEW_COLUMNS_RST  = 9'd320;

    localparam logic signed [31:0] NEAR_LIMIT = 32'sd262144;
    localparam logic [SCALE_W-1:0] STEP_SAT_LIMIT = 24'd4;
    localparam logic [31:0] STEP_SAT_VALUE = 32'h7FFF_FFFF;

    typedef struct packed {
        logic              vis;
        logic              mir;
        logic [FIX25_W-1:0] pw;
        logic [31:0]       wx1;
        logic [31:0]       wx2;
        logic [31:0]       tm;
    } p1_t;

    typedef struct packed {
        logic               vis;
        logic               mir;
        logic               sat;
        logic [SCALE_W-1:0] scale;
        logic [FIX25_W-1:0] pw;
        logic [31:0]        tm;
        logic [COL_W-1:0]   vx1;
        logic [COL_W-1:0]   vx2;
        logic [CLAMP_W-1:0] ccols;
    } p2_t;

endpackage

// File: rtl/sspu_div.sv
// Pipelined restoring unsigned divider, one quotient bit per register stage.
module sspu_div #(
    parameter int NB = 41,
    parameter int DB = 32,
    parameter int QB = 24,
    parameter int PW = 8
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          en,
    input  logic          in_valid,
    input  logic [NB-1:0] dividend,
    input  logic [DB-1:0] divisor,
    input  logic [PW-1:0] in_payload,
    output logic          out_valid,
    output logic [QB-1:0] quotient,
    output logic [PW-1:0] out_payload
);

    logic [DB-1:0] rem_reg [0:QB-1];
    logic [QB-1:0] low_reg [0:QB-1];
    logic [QB-1:0] q_reg   [0:QB-1];
    logic [DB-1:0] d_reg   [0:QB-1];
    logic [PW-1:0] p_reg   [0:QB-1];
    logic          v_reg   [0:QB-1];

    for (genvar k = 0; k < QB; k++) begin : g_stage
        wire [DB-1:0] r_in;
        wire [QB-1:0] l_in;
        wire [QB-1:0] q_in;
        wire [DB-1:0] d_in;
        wire [PW-1:0] p_in;
        wire          v_in;
        wire [DB:0]   t;
        wire [DB:0]   diff;
        wire          ge;

        if (k == 0) begin : g_first
            assign r_in = DB'(dividend >> QB);
            assign l_in = dividend[QB-1:0];
            assign q_in = '0;
            assign d_in = divisor;
            assign p_in = in_payload;
            assign v_in = in_valid;
        end else begin : g_next
            assign r_in = rem_reg[k-1];
            assign l_in = low_reg[k-1];
            assign q_in = q_reg[k-1];
            assign d_in = d_reg[k-1];
            assign p_in = p_reg[k-1];
            assign v_in = v_reg[k-1];
        end

        assign t    = {r_in, l_in[QB-1]};
        assign diff = t - {1'b0, d_in};
        assign ge   = (t >= {1'b0, d_in});

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[k] <= 1'b0;
            end else if (en) begin
                v_reg[k] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k] <= ge ? diff[DB-1:0] : t[DB-1:0];
                low_reg[k] <= {l_in[QB-2:0], 1'b0};
                q_reg[k]   <= {q_in[QB-2:0], ge};
                d_reg[k]   <= d_in;
                p_reg[k]   <= p_in;
            end
        end
    end

    assign out_valid   = v_reg[QB-1];
    assign quotient    = q_reg[QB-1];
    assign out_payload = p_reg[QB-1];

endmodule

// File: rtl/sprite_screen_projection_unit.sv
// Top level of the sprite screen projection unit.
// Projects one sprite per transaction to screen columns and texture stepping. The pipeline
// takes one transaction per cycle while the output is not stalled, and holds two pipelined
// restoring dividers (24 stages for the scale, 30 for the texture step), each
// resolving one quotient bit per stage. Every input gives exactly one result; culled or
// off-screen sprites come out with visible low and all other fields zero.
`include "sprite_screen_projection_unit_assert.svh"

module sprite_screen_projection_unit #(
    parameter int DETAIL_SHIFT = sspu_pkg::DETAIL_SHIFT_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [sspu_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [sspu_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // thing_x, thing_y, thing_z, patch_left_offset, patch_width, patch_top_offset, mirror
    input  logic [175:0]                     s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // visible, left_col, right_col, draw_scale, column_step, start_frac, texture_mid
    output logic [151:0]                     m_tdata
);

    localparam int FB = sspu_pkg::FRAC_BITS;
    localparam int SW = sspu_pkg::SCALE_W;

    logic signed [31:0] view_pos_x_reg, view_pos_y_reg, view_pos_z_reg;
    logic signed [sspu_pkg::TRIG_W-1:0] view_cosine_reg, view_sine_reg;
    logic [sspu_pkg::FIX25_W-1:0] center_column_reg, projection_reg;
    logic [sspu_pkg::COL_W-1:0] view_columns_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            view_pos_x_reg    <= '0;
            view_pos_y_reg    <= '0;
            view_pos_z_reg    <= '0;
            view_cosine_reg   <= sspu_pkg::VIEW_COSINE_RST;
            view_sine_reg     <= '0;
            center_column_reg <= sspu_pkg::CENTER_COLUMN_RST;
            projection_reg    <= sspu_pkg::PROJECTION_RST;
            view_columns_reg  <= sspu_pkg::VIEW_COLUMNS_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                sspu_pkg::REG_VIEW_POS_X:    view_pos_x_reg    <= cfg_wdata;
                sspu_pkg::REG_VIEW_POS_Y:    view_pos_y_reg    <= cfg_wdata;
                sspu_pkg::REG_VIEW_POS_Z:    view_pos_z_reg    <= cfg_wdata;
                sspu_pkg::REG_VIEW_COSINE:   view_cosine_reg   <= cfg_wdata[17:0];
                sspu_pkg::REG_VIEW_SINE:     view_sine_reg     <= cfg_wdata[17:0];
                sspu_pkg::REG_CENTER_COLUMN: center_column_reg <= cfg_wdata[24:0];
                sspu_pkg::REG_PROJECTION:    projection_reg    <= cfg_wdata[24:0];
                sspu_pkg::REG_VIEW_COLUMNS:  view_columns_reg  <= cfg_wdata[8:0];
                default: ;
            endcase
        end
    end

    logic adv;
    assign adv      = !m_tvalid || m_tready;
    assign s_tready = adv;

    // Stage 1: translation.
    logic s1_valid_reg;
    logic signed [31:0] s1_trx_reg, s1_try_reg;
    logic [31:0] s1_tm_reg, s1_loff_reg;
    logic [24:0] s1_pw_reg;
    logic s1_mir_reg;
    logic [31:0] tz_plus_top;

    assign tz_plus_top = s_tdata[95:64] + {{6{s_tdata[172]}}, s_tdata[172:147]};

    // Stage 2: rotation products.
    logic s2_valid_reg;
    logic signed [49:0] m_xc, m_ys, m_xs, m_yc;
    logic [31:0] s2_xc_reg, s2_ys_reg, s2_xs_reg, s2_yc_reg;
    logic [31:0] s2_tm_reg, s2_loff_reg;
    logic [24:0] s2_pw_reg;
    logic s2_mir_reg;

    assign m_xc = s1_trx_reg * view_cosine_reg;
    assign m_ys = s1_try_reg * view_sine_reg;
    assign m_xs = s1_trx_reg * view_sine_reg;
    assign m_yc = s1_try_reg * view_cosine_reg;

    // Stage 3: depth and side.
    logic s3_valid_reg;
    logic signed [31:0] s3_depth_reg, s3_side_reg;
    logic [31:0] s3_tm_reg, s3_loff_reg;
    logic [24:0] s3_pw_reg;
    logic s3_mir_reg;

    // Stage 4: cull test and patch edges.
    logic s4_valid_reg;
    logic [31:0] s4_depth_reg;
    sspu_pkg::p1_t s4_p_reg;
    logic [33:0] abs_side, four_depth;
    logic cull;
    logic [31:0] wx1;

    assign abs_side   = s3_side_reg[31] ? (34'd0 - {{2{s3_side_reg[31]}}, s3_side_reg})
                                        : {2'b0, s3_side_reg};
    assign four_depth = {s3_depth_reg, 2'b00};
    assign cull = (s3_depth_reg < sspu_pkg::NEAR_LIMIT) || (abs_side > four_depth);
    assign wx1  = s3_side_reg - s3_loff_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end else if (adv) begin
            s1_valid_reg <= s_tvalid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_trx_reg  <= s_tdata[31:0] - view_pos_x_reg;
            s1_try_reg  <= s_tdata[63:32] - view_pos_y_reg;
            s1_tm_reg   <= tz_plus_top - view_pos_z_reg;
            s1_loff_reg <= {{6{s_tdata[121]}}, s_tdata[121:96]};
            s1_pw_reg   <= s_tdata[146:122];
            s1_mir_reg  <= s_tdata[173];

            s2_xc_reg   <= m_xc[47:16];
            s2_ys_reg   <= m_ys[47:16];
            s2_xs_reg   <= m_xs[47:16];
            s2_yc_reg   <= m_yc[47:16];
            s2_tm_reg   <= s1_tm_reg;
            s2_loff_reg <= s1_loff_reg;
            s2_pw_reg   <= s1_pw_reg;
            s2_mir_reg  <= s1_mir_reg;

            s3_depth_reg <= s2_xc_reg + s2_ys_reg;
            s3_side_reg  <= s2_xs_reg - s2_yc_reg;
            s3_tm_reg    <= s2_tm_reg;
            s3_loff_reg  <= s2_loff_reg;
            s3_pw_reg    <= s2_pw_reg;
            s3_mir_reg   <= s2_mir_reg;

            s4_depth_reg <= s3_depth_reg;
            s4_p_reg.vis <= !cull;
            s4_p_reg.mir <= s3_mir_reg;
            s4_p_reg.pw  <= s3_pw_reg;
            s4_p_reg.wx1 <= wx1;
            s4_p_reg.wx2 <= wx1 + {7'b0, s3_pw_reg};
            s4_p_reg.tm  <= s3_tm_reg;
        end
    end

    // Scale = projection / depth.
    logic d1_valid;
    logic [SW-1:0] d1_q;
    sspu_pkg::p1_t d1_p;

    sspu_div #(
        .NB(sspu_pkg::FIX25_W + FB),
        .DB(32),
        .QB(SW),
        .PW($bits(sspu_pkg::p1_t))
    ) u_scale_div (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (adv),
        .in_valid   (s4_valid_reg),
        .dividend   ({projection_reg, {FB{1'b0}}}),
        .divisor    (s4_depth_reg),
        .in_payload (s4_p_reg),
        .out_valid  (d1_valid),
        .quotient   (d1_q),
        .out_payload(d1_p)
    );

    // Stage 5: edge products.
    logic s5_valid_reg;
    logic signed [56:0] m_e1, m_e2;
    logic [31:0] s5_e1_reg, s5_e2_reg;
    logic [SW-1:0] s5_scale_reg;
    sspu_pkg::p1_t s5_p_reg;

    assign m_e1 = $signed(d1_p.wx1) * $signed({1'b0, d1_q});
    assign m_e2 = $signed(d1_p.wx2) * $signed({1'b0, d1_q});

    // Stage 6: columns.
    logic s6_valid_reg;
    sspu_pkg::p2_t s6_p_reg;
    logic [31:0] px1, px2;
    logic signed [16:0] x1, x2, vw_s;
    logic on_screen;

    assign px1  = center_column_reg + s5_e1_reg;
    assign px2  = center_column_reg + s5_e2_reg;
    assign x1   = {px1[31], px1[31:16]};
    assign x2   = $signed({px2[31], px2[31:16]}) - 17'sd1;
    assign vw_s = {8'b0, view_columns_reg};
    assign on_screen = (x1 <= vw_s) && !x2[16];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s5_valid_reg <= 1'b0;
            s6_valid_reg <= 1'b0;
        end else if (adv) begin
            s5_valid_reg <= d1_valid;
            s6_valid_reg <= s5_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s5_e1_reg    <= m_e1[47:16];
            s5_e2_reg    <= m_e2[47:16];
            s5_scale_reg <= d1_q;
            s5_p_reg     <= d1_p;

            s6_p_reg.vis   <= s5_p_reg.vis && on_screen;
            s6_p_reg.mir   <= s5_p_reg.mir;
            s6_p_reg.sat   <= (s5_scale_reg <= sspu_pkg::STEP_SAT_LIMIT);
            s6_p_reg.scale <= s5_scale_reg;
            s6_p_reg.pw    <= s5_p_reg.pw;
            s6_p_reg.tm    <= s5_p_reg.tm;
            s6_p_reg.vx1   <= x1[16] ? 9'd0 : x1[8:0];
            s6_p_reg.vx2   <= (x2 >= vw_s) ? (view_columns_reg - 9'd1) : x2[8:0];
            s6_p_reg.ccols <= x1[16] ? (~x1 + 17'd1) : 17'd0;
        end
    end

    // Step = 1.0 / scale; small scales saturate, so feed a safe divisor.
    logic d2_valid;
    logic [sspu_pkg::ISTEP_Q_W-1:0] d2_q;
    sspu_pkg::p2_t d2_p;
    logic [SW-1:0] d2_divisor;

    assign d2_divisor = s6_p_reg.sat ? (sspu_pkg::STEP_SAT_LIMIT + 24'd1) : s6_p_reg.scale;

    sspu_div #(
        .NB(33),
        .DB(SW),
        .QB(sspu_pkg::ISTEP_Q_W),
        .PW($bits(sspu_pkg::p2_t))
    ) u_step_div (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (adv),
        .in_valid   (s6_valid_reg),
        .dividend   ({1'b1, 32'd0}),
        .divisor    (d2_divisor),
        .in_payload (s6_p_reg),
        .out_valid  (d2_valid),
        .quotient   (d2_q),
        .out_payload(d2_p)
    );

    // Stage 7: signed step and clamp advance.
    logic s7_valid_reg;
    logic [31:0] istep, step;
    logic [48:0] m_adv;
    logic [31:0] s7_step_reg, s7_adv_reg, s7_frac0_reg;
    sspu_pkg::p2_t s7_p_reg;

    assign istep = d2_p.sat ? sspu_pkg::STEP_SAT_VALUE : {2'b00, d2_q};
    assign step  = d2_p.mir ? (32'd0 - istep) : istep;
    assign m_adv = step * d2_p.ccols;

    // Output register.
    logic out_valid_reg;
    logic [151:0] out_data_reg;
    logic [31:0] draw_scale, frac;

    assign draw_scale = 32'({8'b0, s7_p_reg.scale} << DETAIL_SHIFT);
    assign frac       = s7_frac0_reg + s7_adv_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s7_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            s7_valid_reg  <= d2_valid;
            out_valid_reg <= s7_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s7_step_reg  <= step;
            s7_adv_reg   <= m_adv[31:0];
            s7_frac0_reg <= d2_p.mir ? ({7'b0, d2_p.pw} - 32'd1) : 32'd0;
            s7_p_reg     <= d2_p;

            if (s7_p_reg.vis) begin
                out_data_reg <= {5'b0, s7_p_reg.tm, frac, s7_step_reg, draw_scale,
                                 s7_p_reg.vx2, s7_p_reg.vx1, 1'b1};
            end else begin
                out_data_reg <= '0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    logic out_shown;
    assign out_shown = m_tvalid && m_tdata[0];

    `SSPU_ASSERT_IMPL(a_hidden_zero, aclk, aresetn, m_tvalid && !m_tdata[0], m_tdata[151:1] == '0)
    `SSPU_ASSERT_IMPL(a_left_in_view, aclk, aresetn, out_shown, m_tdata[9:1] <= view_columns_reg)
    `SSPU_ASSERT_NEXT(a_stall_holds_front, aclk, aresetn, !adv, $stable(s4_valid_reg))
    `SSPU_ASSERT_NEXT(a_stall_holds_back, aclk, aresetn, !adv, $stable(s7_valid_reg))

endmodule

// File: sim/tb.sv
// Self-checking testbench for the sprite screen projection unit.
module tb;

    localparam int DSHIFT = sspu_pkg::DETAIL_SHIFT_DEF;
    localparam int STALL_LIMIT = 5000;
    localparam int DRAIN_CYCLES = 80;

    typedef struct {
        bit        vis;
        bit [8:0]  lcol;
        bit [8:0]  rcol;
        bit [31:0] scale;
        bit [31:0] step;
        bit [31:0] frac;
        bit [31:0] tmid;
    } sprite_span_t;

    logic         aclk;
    logic         aresetn;
    logic         cfg_wr_en;
    logic [2:0]   cfg_index;
    logic [31:0]  cfg_wdata;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [175:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [151:0] m_tdata;

    int view_x, view_y, view_z, view_cos, view_sin, center_col, proj_k, view_cols;
    int send_idle_pct, recv_idle_pct;
    int errors;
    int stall_cycles;
    logic [175:0] pending_sprites[$];
    sprite_span_t expected_spans[$];

    sprite_screen_projection_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic int fix_mul(int a, int b);
        longint p;
        p = longint'(a) * longint'(b);
        return int'(p >>> sspu_pkg::FRAC_BITS);
    endfunction

    function automatic int fix_div(int a, int b);
        longint aa, ab, q;
        aa = a < 0 ? -longint'(a) : longint'(a);
        ab = b < 0 ? -longint'(b) : longint'(b);
        if ((aa >>> 14) >= ab)
            return ((a < 0) != (b < 0)) ? 32'h8000_0000 : 32'h7FFF_FFFF;
        q = (longint'(a) * 65536) / longint'(b);
        return int'(q);
    endfunction

    function automatic sprite_span_t project_sprite(logic [175:0] d);
        sprite_span_t r;
        int trx, try_, depth, side, scale, loff, pw, toff, wx1, wx2, px1, px2;
        int x1, x2, vx1, vx2, istep, step, frac;
        longint aside;
        r = '{default: 0};
        loff = int'($signed(d[121:96]));
        pw = int'({7'b0, d[146:122]});
        toff = int'($signed(d[172:147]));
        trx = int'(d[31:0]) - view_x;
        try_ = int'(d[63:32]) - view_y;
        depth = fix_mul(trx, view_cos) + fix_mul(try_, view_sin);
        side = fix_mul(trx, view_sin) - fix_mul(try_, view_cos);
        aside = side < 0 ? -longint'(side) : longint'(side);
        if (depth < 262144 || aside > longint'(depth) * 4)
            return r;
        scale = fix_div(proj_k, depth);
        wx1 = side - loff;
        wx2 = wx1 + pw;
        px1 = center_col + fix_mul(wx1, scale);
        px2 = center_col + fix_mul(wx2, scale);
        x1 = px1 >>> sspu_pkg::FRAC_BITS;
        x2 = (px2 >>> sspu_pkg::FRAC_BITS) - 1;
        if (!(x1 <= view_cols && x2 >= 0))
            return r;
        vx1 = x1 < 0 ? 0 : x1;
        vx2 = x2 >= view_cols ? view_cols - 1 : x2;
        istep = fix_div(65536, scale);
        if (d[173]) begin
            frac = pw - 1;
            step = -istep;
        end else begin
            frac = 0;
            step = istep;
        end
        if (vx1 > x1)
            frac = frac + step * (vx1 - x1);
        r.vis = 1'b1;
        r.lcol = vx1[8:0];
        r.rcol = vx2[8:0];
        r.scale = scale << DSHIFT;
        r.step = step;
        r.frac = frac;
        r.tmid = int'(d[95:64]) + toff - view_z;
        return r;
    endfunction

    function automatic logic [175:0] pack_sprite(int x, int y, int z, int loff, int pw,
                                                 int toff, bit mir);
        return {2'b0, mir, toff[25:0], pw[24:0], loff[25:0], z, y, x};
    endfunction

    task automatic add_sprite(int x, int y, int z, int loff, int pw, int toff, bit mir);
        pending_sprites.push_back(pack_sprite(x, y, z, loff, pw, toff, mir));
    endtask

    task automatic add_random_sprite();
        longint dep, sd, wx, wy;
        int pw, loff, toff;
        if ($urandom_range(99) < 15) begin
            pending_sprites.push_back(176'({$urandom, $urandom, $urandom, $urandom,
                                            $urandom, $urandom}));
        end else begin
            dep = $urandom_range(($urandom_range(3) == 0) ? 32'h7FFF_FFFF : 32'h0100_0000,
                                 262144);
            sd = longint'($urandom_range(32'h7FFF_FFFF)) % (3 * dep + 1);
            if ($urandom_range(1)) sd = -sd;
            wx = view_x + ((dep * view_cos + sd * view_sin) >>> 16);
            wy = view_y + ((dep * view_sin - sd * view_cos) >>> 16);
            pw = $urandom_range(4194304);
            loff = int'($urandom_range(4194304)) - 2097152;
            toff = int'($urandom_range(33554432)) - 16777216;
            add_sprite(int'(wx), int'(wy), $urandom, loff, pw, toff, 1'($urandom_range(1)));
        end
    endtask

    task automatic write_view(int x, int y, int z, int c, int s, int cc, int pk, int cols);
        int vals[8];
        vals = '{x, y, z, c, s, cc, pk, cols};
        for (int i = 0; i < 8; i++) begin
            @(posedge aclk);
            cfg_wr_en <= 1'b1;
            cfg_index <= i[2:0];
            cfg_wdata <= vals[i];
        end
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        view_x = x;
        view_y = y;
        view_z = z;
        view_cos = int'($signed(c[17:0]));
        view_sin = int'($signed(s[17:0]));
        center_col = int'({7'b0, cc[24:0]});
        proj_k = int'({7'b0, pk[24:0]});
        view_cols = int'({23'b0, cols[8:0]});
    endtask

    task automatic report_mismatch(string what, bit [31:0] got, bit [31:0] want);
        $display("mismatch on %s: got %h, expected %h", what, got, want);
        errors++;
    endtask

    // Driver: presents pending sprites and predicts each accepted transaction.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (s_tvalid)
                expected_spans.push_back(project_sprite(s_tdata));
            if (pending_sprites.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                s_tvalid <= 1'b1;
                s_tdata <= pending_sprites.pop_front();
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Monitor: checks each result transaction against the oldest prediction.
    always @(posedge aclk) begin
        sprite_span_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_spans.size() == 0) begin
                    $display("result transaction with no prediction pending");
                    errors++;
                end else begin
                    want = expected_spans.pop_front();
                    if (m_tdata[0] !== want.vis)
                        report_mismatch("visible", 32'(m_tdata[0]), 32'(want.vis));
                    if (m_tdata[9:1] !== want.lcol)
                        report_mismatch("left_col", 32'(m_tdata[9:1]), 32'(want.lcol));
                    if (m_tdata[18:10] !== want.rcol)
                        report_mismatch("right_col", 32'(m_tdata[18:10]), 32'(want.rcol));
                    if (m_tdata[50:19] !== want.scale)
                        report_mismatch("draw_scale", m_tdata[50:19], want.scale);
                    if (m_tdata[82:51] !== want.step)
                        report_mismatch("column_step", m_tdata[82:51], want.step);
                    if (m_tdata[114:83] !== want.frac)
                        report_mismatch("start_frac", m_tdata[114:83], want.frac);
                    if (m_tdata[146:115] !== want.tmid)
                        report_mismatch("texture_mid", m_tdata[146:115], want.tmid);
                end
            end
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("sprite_screen_projection_unit verification failed");
            $finish;
        end
    end

    initial begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: write_view(0, 0, 0, 65536, 0, 10485760, 10485760, 320);
                1: write_view($urandom, $urandom, $urandom, -65536, 0, 10485760, 20971520, 320);
                2: write_view($urandom, $urandom, $urandom, 0, 65536, 0, 10485760, 1);
                3: write_view(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 0, -65536,
                              20971520, 10485760, 320);
                4: write_view($urandom, $urandom, $urandom, 46341, 46341, 5000000, 2000000, 200);
                5: write_view($urandom, $urandom, 32'h7FFF_FFFF, int'($urandom_range(131072)) - 65536,
                              int'($urandom_range(131072)) - 65536, $urandom_range(20971520),
                              $urandom_range(20971520), $urandom_range(320, 1));
                6: write_view($urandom, $urandom, $urandom, 65536, 0, 10485760, 0, 0);
                default: write_view($urandom, $urandom, $urandom, -46341, 46341, 20971520,
                                    10485760, 511);
            endcase
            send_idle_pct = (ph % 4 == 1) ? 49 : (ph % 4 == 3) ? 12 : 0;
            recv_idle_pct = (ph % 4 == 2) ? 49 : (ph % 4 == 3) ? 12 : 0;
            if (ph == 0) begin
                add_sprite(262144, 0, 0, 0, 1048576, 0, 0);
                add_sprite(262143, 0, 0, 0, 1048576, 0, 0);
                add_sprite(262144, -1048576, 0, 0, 1048576, 0, 0);
                add_sprite(262144, -1048577, 0, 0, 1048576, 0, 0);
                add_sprite(262144, 1048576, 0, 0, 1048576, 0, 1);
                add_sprite(262144, 0, 0, 16777216, 16777216, 0, 0);
                add_sprite(262144, 0, 0, 16777216, 16777216, 0, 1);
                add_sprite(262144, 0, 0, -16777216, 0, 0, 0);
                add_sprite(32'h7FFF_FFFF, 0, 32'h7FFF_FFFF, 0, 16777216, 16777216, 0);
                add_sprite(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 0, -16777216, 1);
                add_sprite(32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, -16777216, 65536, 16777216, 1);
                add_sprite(655360, 65536, 1000, 32768, 65536, 4096, 0);
                add_sprite(655360, -65536, -1000, -32768, 65536, -4096, 1);
                add_sprite(0, 0, 0, 0, 0, 0, 0);
                add_sprite(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, -1, 33554431, -1, 1);
                add_sprite(10485760, 0, 0, 0, 65536, 0, 0);
            end
            for (int i = 0; i < 125; i++)
                add_random_sprite();
            while (pending_sprites.size() > 0 || s_tvalid || expected_spans.size() > 0)
                @(negedge aclk);
            repeat (DRAIN_CYCLES) @(posedge aclk);
        end
        if (errors == 0)
            $display("sprite_screen_projection_unit verification clean");
        else
            $display("sprite_screen_projection_unit verification failed");
        $finish;
    end
endmodule

// File: filelist.f
+incdir+rtl
rtl/sspu_pkg.sv
rtl/sspu_div.sv
rtl/sprite_screen_projection_unit.sv
sim/tb.sv
